// ===== hdl/awc_pkg.sv =====
package awc_pkg;

  localparam int MAX_PATTERN   = 64;
  localparam int ALPHABET_SIZE = 256;

  localparam int SYM_W   = 8;
  localparam int CMD_W   = 2;
  localparam int TOTAL_W = 32;
  localparam int PTR_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W   = $clog2(MAX_PATTERN + 1);
  localparam int BAL_W   = CNT_W + 1;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT  = 2'd2;

  localparam logic [SYM_W:0]     ALPHA_LIM   = (SYM_W + 1)'(ALPHABET_SIZE);
  localparam logic [CNT_W-1:0]   PAT_LIM     = CNT_W'(MAX_PATTERN);
  localparam logic [PTR_W-1:0]   PTR_LAST    = PTR_W'(MAX_PATTERN - 1);
  localparam logic [PTR_W-1:0]   DEP_INIT    = PTR_W'(1 % MAX_PATTERN);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [BAL_W-1:0] bal_t;

  // requests into the window tracker, already qualified by the handshake
  typedef struct packed {
    logic clear;
    logic load;
    logic text;
    sym_t sym;
  } win_req_t;

  typedef struct packed {
    logic load_ok;
    logic depart;
    sym_t gone;
  } win_stat_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic text;
    logic depart;
    sym_t sym;
    sym_t gone;
  } slot_ctl_t;

  typedef struct packed {
    logic arr_zero;
    logic dep_zero;
    cnt_t distinct;
  } slot_stat_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_LAST : p - PTR_W'(1);
  endfunction

endpackage

// ===== hdl/awc_ram.sv =====
module awc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on an address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/awc_window.sv =====
module awc_window
  import awc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  win_req_t  req,
  output win_stat_t stat
);

  ptr_t ring_wr_r, ring_wr_nxt;
  ptr_t dep_ptr_r, dep_ptr_nxt;
  cnt_t plen_r, plen_nxt;
  cnt_t tpos_r, tpos_nxt;
  logic byp_r, byp_nxt;
  sym_t byp_data_r;
  sym_t rd_q;
  sym_t q_eff;
  cnt_t tpos_after;

  // dep_ptr_r always tracks ring_wr + 1 - pattern length, modulo the ring depth
  awc_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_PATTERN)
  ) u_ring (
    .clk   (clk),
    .we    (req.text),
    .waddr (ring_wr_r),
    .wdata (req.sym),
    .raddr (dep_ptr_nxt),
    .rdata (rd_q)
  );

  assign q_eff      = byp_r ? byp_data_r : rd_q;
  assign tpos_after = (tpos_r < plen_r) ? tpos_r + CNT_W'(1) : tpos_r;

  always_comb begin
    stat.load_ok = req.load && (tpos_r == '0) && (plen_r < PAT_LIM) &&
                   ({1'b0, req.sym} < ALPHA_LIM);
    stat.depart  = req.text && (plen_r != '0) && (tpos_after == plen_r);
    // a one-character pattern drops the character that just arrived
    stat.gone    = (dep_ptr_r == ring_wr_r) ? req.sym : q_eff;
  end

  always_comb begin
    ring_wr_nxt = ring_wr_r;
    dep_ptr_nxt = dep_ptr_r;
    plen_nxt    = plen_r;
    tpos_nxt    = tpos_r;
    if (req.clear) begin
      ring_wr_nxt = '0;
      dep_ptr_nxt = DEP_INIT;
      plen_nxt    = '0;
      tpos_nxt    = '0;
    end else if (stat.load_ok) begin
      plen_nxt    = plen_r + CNT_W'(1);
      dep_ptr_nxt = ptr_dec(dep_ptr_r);
    end else if (req.text) begin
      ring_wr_nxt = ptr_inc(ring_wr_r);
      dep_ptr_nxt = ptr_inc(dep_ptr_r);
      tpos_nxt    = tpos_after;
    end
    byp_nxt = req.text && (ring_wr_r == dep_ptr_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_wr_r <= '0;
      dep_ptr_r <= DEP_INIT;
      plen_r    <= '0;
      tpos_r    <= '0;
      byp_r     <= 1'b0;
    end else begin
      ring_wr_r <= ring_wr_nxt;
      dep_ptr_r <= dep_ptr_nxt;
      plen_r    <= plen_nxt;
      tpos_r    <= tpos_nxt;
      byp_r     <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= req.sym;
  end

endmodule

// ===== hdl/awc_slots.sv =====
module awc_slots
  import awc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  slot_ctl_t  ctl,
  output slot_stat_t stat
);

  logic used_r   [MAX_PATTERN];
  logic used_nxt [MAX_PATTERN];
  sym_t sym_r    [MAX_PATTERN];
  sym_t sym_nxt  [MAX_PATTERN];
  bal_t bal_r    [MAX_PATTERN];
  bal_t bal_nxt  [MAX_PATTERN];
  cnt_t distinct_r, distinct_nxt;

  logic [MAX_PATTERN-1:0] arr_hit;
  logic [MAX_PATTERN-1:0] dep_hit;
  logic [MAX_PATTERN-1:0] arr_zero;
  logic [MAX_PATTERN-1:0] dep_zero;
  bal_t                   bal_a [MAX_PATTERN];
  ptr_t                   alloc;

  assign alloc = distinct_r[PTR_W-1:0];

  // one slot per distinct pattern character, looked up by symbol compare
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      arr_hit[i]  = used_r[i] && (sym_r[i] == ctl.sym);
      dep_hit[i]  = ctl.depart && used_r[i] && (sym_r[i] == ctl.gone);
      bal_a[i]    = bal_r[i] - {{(BAL_W-1){1'b0}}, ctl.text && arr_hit[i]};
      arr_zero[i] = ctl.text && arr_hit[i] && (bal_r[i] == BAL_W'(1));
      dep_zero[i] = dep_hit[i] && (bal_a[i] == '0);
    end

    for (int i = 0; i < MAX_PATTERN; i++) begin
      used_nxt[i] = used_r[i];
      sym_nxt[i]  = sym_r[i];
      bal_nxt[i]  = bal_r[i];
      if (ctl.clear) begin
        used_nxt[i] = 1'b0;
      end else if (ctl.load) begin
        if (arr_hit[i]) begin
          bal_nxt[i] = bal_r[i] + BAL_W'(1);
        end else if (!(|arr_hit) && (alloc == PTR_W'(i))) begin
          used_nxt[i] = 1'b1;
          sym_nxt[i]  = ctl.sym;
          bal_nxt[i]  = BAL_W'(1);
        end
      end else if (ctl.text) begin
        bal_nxt[i] = bal_a[i] + {{(BAL_W-1){1'b0}}, dep_hit[i]};
      end
    end

    distinct_nxt = distinct_r;
    if (ctl.clear) begin
      distinct_nxt = '0;
    end else if (ctl.load && !(|arr_hit)) begin
      distinct_nxt = distinct_r + CNT_W'(1);
    end
  end

  assign stat.arr_zero = |arr_zero;
  assign stat.dep_zero = |dep_zero;
  assign stat.distinct = distinct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      distinct_r <= '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        used_r[i] <= 1'b0;
      end
    end else begin
      distinct_r <= distinct_nxt;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        used_r[i] <= used_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      sym_r[i] <= sym_nxt[i];
      bal_r[i] <= bal_nxt[i];
    end
  end

endmodule

// ===== hdl/anagram_window_counter.sv =====
// Counts text positions whose trailing window of pattern-length characters is a
// permutation of the loaded pattern. Requests on in_* carry a command in tuser:
// clear empties all state, load adds a pattern character (only before the first
// text character taken with a non-empty pattern since the last clear, up to 64
// characters), text runs the window and returns one result with the match flag
// and a saturating 32-bit total; tlast is copied through to out_tlast. A text request
// passes the input register, then the output register that drives out_tvalid. One
// request can be taken every clock cycle, but a text request waits in the input
// register while an earlier result is held in the output register (clear and load
// requests still pass), so out_tready reaches in_tready in the same cycle. The rate
// is set by the single update pass over the per-character slot row and the ring
// buffer of recent text, whose departing character is prefetched.
module anagram_window_counter
  import awc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  input  logic        in_tlast,   // text_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] window_match, [32:1] match_total, [39:33] zero
  output logic        out_tlast   // final_result
);

  logic                 in_v_r;
  logic [CMD_W-1:0]     cmd_r;
  sym_t                 sym_r;
  logic                 end_r;
  logic                 out_v_r, out_v_nxt;
  logic                 match_out_r;
  logic [TOTAL_W-1:0]   total_out_r;
  logic                 last_out_r;
  cnt_t                 matched_r, matched_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;

  logic       out_free;
  logic       fire;
  logic       do_text;
  logic       match;
  cnt_t       matched_arr;
  win_req_t   wreq;
  win_stat_t  wstat;
  slot_ctl_t  sctl;
  slot_stat_t sstat;

  assign out_free  = !out_v_r || out_tready;
  assign fire      = in_v_r && ((cmd_r != CMD_TEXT) || out_free);
  assign in_tready = !in_v_r || fire;
  assign do_text   = fire && (cmd_r == CMD_TEXT);

  assign wreq.clear = fire && (cmd_r == CMD_CLEAR);
  assign wreq.load  = fire && (cmd_r == CMD_LOAD);
  assign wreq.text  = do_text;
  assign wreq.sym   = sym_r;

  awc_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (wreq),
    .stat  (wstat)
  );

  assign sctl.clear  = wreq.clear;
  assign sctl.load   = wstat.load_ok;
  assign sctl.text   = do_text;
  assign sctl.depart = wstat.depart;
  assign sctl.sym    = sym_r;
  assign sctl.gone   = wstat.gone;

  awc_slots u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sctl),
    .stat  (sstat)
  );

  // match is judged after the arriving character, before the departing one
  always_comb begin
    matched_arr = matched_r + CNT_W'(sstat.arr_zero);
    match       = (matched_arr == sstat.distinct);
    matched_nxt = matched_r;
    total_nxt   = total_r;
    if (wreq.clear) begin
      matched_nxt = '0;
      total_nxt   = '0;
    end else if (do_text) begin
      matched_nxt = matched_arr - CNT_W'(sstat.dep_zero);
      if (match && (total_r != TOTAL_MAX)) begin
        total_nxt = total_r + TOTAL_W'(1);
      end
    end
    out_v_nxt = do_text ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      matched_r <= '0;
      total_r   <= '0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      out_v_r   <= out_v_nxt;
      matched_r <= matched_nxt;
      total_r   <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r <= in_tuser;
      sym_r <= in_tdata;
      end_r <= in_tlast;
    end
    if (do_text) begin
      match_out_r <= match;
      total_out_r <= total_nxt;
      last_out_r  <= end_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, total_out_r, match_out_r};
  assign out_tlast  = last_out_r;

endmodule

// ===== tb/anagram_window_counter_tb.sv =====
module anagram_window_counter_tb;
  import awc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1850;

  typedef struct {
    logic               window_match;
    logic [TOTAL_W-1:0] match_total;
    logic               final_result;
  } anagram_result_t;

  // Tracks the pattern balance and the text window, and holds the results still owed
  class anagram_tracker;
    int                 balance[ALPHABET_SIZE];
    bit                 present[ALPHABET_SIZE];
    sym_t               ring[MAX_PATTERN];
    int                 distinct, pat_len, matched, ring_wr, text_seen;
    logic [TOTAL_W-1:0] total;
    anagram_result_t    expected_q[$];
    int                 errors, results_seen, matches_seen, texts, loads, clears;

    function new();
      wipe();
    endfunction

    function void wipe();
      foreach (balance[i]) begin
        balance[i] = 0;
        present[i] = 1'b0;
      end
      foreach (ring[i]) ring[i] = '0;
      distinct  = 0;
      pat_len   = 0;
      matched   = 0;
      ring_wr   = 0;
      text_seen = 0;
      total     = '0;
    endfunction

    function bit in_pattern(int s);
      return s < ALPHABET_SIZE && present[s];
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, sym_t sym, logic last);
      anagram_result_t r;
      int              here, idx;
      sym_t            gone;
      case (cmd)
        CMD_CLEAR: begin
          clears++;
          wipe();
        end
        CMD_LOAD: begin
          loads++;
          // loads after the first text character, or past the pattern limit, are dropped
          if (text_seen == 0 && pat_len < MAX_PATTERN && int'(sym) < ALPHABET_SIZE) begin
            if (!present[sym]) begin
              present[sym] = 1'b1;
              distinct++;
            end
            balance[sym]++;
            pat_len++;
          end
        end
        CMD_TEXT: begin
          texts++;
          if (in_pattern(sym)) begin
            balance[sym]--;
            if (balance[sym] == 0) matched++;
          end
          r.window_match = (matched == distinct);
          if (r.window_match && total != '1) total++;
          r.match_total  = total;
          r.final_result = last;
          expected_q.push_back(r);
          here = ring_wr;
          ring[here] = sym;
          ring_wr = (ring_wr + 1) % MAX_PATTERN;
          if (text_seen < pat_len) text_seen++;
          // oldest character leaves once the window is full
          if (pat_len != 0 && text_seen >= pat_len) begin
            idx  = (here + MAX_PATTERN + 1 - pat_len) % MAX_PATTERN;
            gone = ring[idx];
            if (in_pattern(gone)) begin
              if (balance[gone] == 0) matched--;
              balance[gone]++;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic m, logic [TOTAL_W-1:0] tot, logic last, logic [6:0] pad);
      anagram_result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: window_match %0d, match_total %0d", m, tot);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (m === 1'b1) matches_seen++;
      if (m !== e.window_match) begin
        $error("window_match: expected %0d, actual %0d", e.window_match, m);
        errors++;
      end
      if (tot !== e.match_total) begin
        $error("match_total: expected %0d, actual %0d", e.match_total, tot);
        errors++;
      end
      if (last !== e.final_result) begin
        $error("final_result: expected %0d, actual %0d", e.final_result, last);
        errors++;
      end
      if (pad !== 7'd0) begin
        $error("tdata padding: expected 0, actual %0h", pad);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;
  logic [1:0]        in_tuser   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [39:0]       out_tdata;
  logic              out_tlast;

  anagram_tracker    tracker = new();
  int                items_sent = 0;
  int                long_holds = 0;
  bit                no_gaps = 1'b0;
  bit                draining = 1'b0;

  always #5 clk = ~clk;

  anagram_window_counter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // requests are noted before results are checked, so ordering within an edge is moot
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.note_request(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready)
        tracker.check_result(out_tdata[0], out_tdata[32:1], out_tlast, out_tdata[39:33]);
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    int calm_left;
    int r;
    bit held;
    stall     = 0;
    calm_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && tracker.results_seen >= 300) begin
        // long hold so the block fills and stalls its input
        held = 1'b1;
        long_holds++;
        repeat (300) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
      end
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 299) == 0) calm_left = $urandom_range(50, 150);
      if (draining) begin
        out_tready <= 1'b1;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        r = $urandom_range(0, 99);
        if (calm_left > 0) stall = 0;
        else if (r < 15) stall = $urandom_range(1, 3);
        else if (r < 19) stall = $urandom_range(4, 12);
        else if (r < 20) stall = $urandom_range(20, 50);
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input sym_t sym, input logic last);
    int gap;
    gap = sender_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= sym;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic send_text(input sym_t sym, input logic last);
    send_request(CMD_TEXT, sym, last);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // one sequence of an optional clear, loads and text with random content and some noise
  task automatic run_sequence();
    sym_t pool[4];
    sym_t pat[$];
    sym_t perm[$];
    sym_t tmp;
    int   plen, npool, tlen, eff, i, j, k, r;
    no_gaps = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 9) != 0) send_request(CMD_CLEAR, sym_t'($urandom), 1'($urandom));
    r = $urandom_range(0, 99);
    if (r < 3) plen = 0;
    else if (r < 85) plen = $urandom_range(1, 6);
    else if (r < 95) plen = $urandom_range(7, 20);
    else plen = $urandom_range(60, 70);
    npool = $urandom_range(1, 4);
    for (i = 0; i < 4; i++) pool[i] = sym_t'($urandom);
    pat = {};
    for (i = 0; i < plen; i++) begin
      pat.push_back(pool[$urandom_range(0, npool - 1)]);
      if ($urandom_range(0, 29) == 0)
        send_request(CMD_UNUSED, sym_t'($urandom), 1'($urandom));
      send_request(CMD_LOAD, pat[i], 1'($urandom));
    end
    eff  = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
    tlen = (plen > 20) ? 2 * plen + $urandom_range(0, 20) : $urandom_range(8, 40);
    i = 0;
    while (i < tlen) begin
      r = $urandom_range(0, 99);
      if (r < 25 && eff > 0) begin
        perm = pat[0:eff-1];
        for (j = eff - 1; j > 0; j--) begin
          k = $urandom_range(0, j);
          tmp = perm[j];
          perm[j] = perm[k];
          perm[k] = tmp;
        end
        foreach (perm[n]) send_text(perm[n], ($urandom_range(0, 49) == 0));
        i += eff;
      end else if (r < 28) begin
        send_request(CMD_LOAD, pool[$urandom_range(0, npool - 1)], 1'($urandom));
      end else if (r < 30) begin
        send_request(CMD_UNUSED, sym_t'($urandom), 1'($urandom));
      end else begin
        if (r < 85 && eff > 0) tmp = pool[$urandom_range(0, npool - 1)];
        else tmp = sym_t'($urandom);
        send_text(tmp, (i == tlen - 1) || ($urandom_range(0, 49) == 0));
        i++;
      end
    end
    if ($urandom_range(0, 9) == 0) wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty pattern: every text character matches
    send_request(CMD_CLEAR, 8'h00, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b1);
    // pattern {00, FF, 00} with noise, a stray text character and a late load
    send_request(CMD_CLEAR, 8'hFF, 1'b1);
    send_request(CMD_LOAD, 8'h00, 1'b0);
    send_request(CMD_LOAD, 8'hFF, 1'b1);
    send_request(CMD_LOAD, 8'h00, 1'b0);
    send_request(CMD_UNUSED, 8'hAA, 1'b1);
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h5A, 1'b0);
    send_request(CMD_LOAD, 8'h5A, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b1);
    // end of string does not restart counting
    send_text(8'h00, 1'b0);
    // single-character pattern
    send_request(CMD_CLEAR, 8'h55, 1'b0);
    send_request(CMD_LOAD, 8'h80, 1'b0);
    send_text(8'h80, 1'b1);
    send_text(8'h7F, 1'b0);
    send_text(8'h80, 1'b0);
    wait_drained();

    while (items_sent < ITEM_TARGET) run_sequence();
    @(negedge clk);
    in_tvalid <= 1'b0;
    draining = 1'b1;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests: %0d clears, %0d loads, %0d text characters",
             items_sent, tracker.clears, tracker.loads, tracker.texts);
    $display("checked %0d results, %0d window matches, %0d long output holds",
             tracker.results_seen, tracker.matches_seen, long_holds);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", tracker.pending());
    $display("status: fail");
    $finish;
  end

endmodule
